[hw/rtl/pcr_pkg.sv]
// Shared widths and constants of the particle contact resolver.
// Used by the channel interfaces, the top level and the bench. No dependencies.
package pcr_pkg;

	localparam int LANE_W  = 16;
	localparam int NLANES  = 3;
	localparam int VEC_W   = LANE_W * NLANES;
	localparam int IM_W    = 16;
	localparam int TOT_W   = IM_W + 1;
	localparam int E_W     = 9;
	localparam int TS_W    = 16;
	localparam int DQ_W    = 36;
	localparam int PEN_QW  = LANE_W - 1;

	localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd1092;

endpackage

[hw/rtl/pcr_contact_if.sv]
// Contact channel: one beat carries one contact.
// Depends on pcr_pkg.
interface pcr_contact_if;
	logic                         valid;
	logic                         ready;
	logic [pcr_pkg::VEC_W-1:0]    first_velocity;
	logic [pcr_pkg::VEC_W-1:0]    second_velocity;
	logic [pcr_pkg::VEC_W-1:0]    first_acceleration;
	logic [pcr_pkg::VEC_W-1:0]    second_acceleration;
	logic [pcr_pkg::VEC_W-1:0]    first_position;
	logic [pcr_pkg::VEC_W-1:0]    second_position;
	logic [pcr_pkg::IM_W-1:0]     first_inverse_mass;
	logic [pcr_pkg::IM_W-1:0]     second_inverse_mass;
	logic                         has_second;
	logic [pcr_pkg::VEC_W-1:0]    contact_normal;
	logic [pcr_pkg::E_W-1:0]      restitution;
	logic signed [pcr_pkg::LANE_W-1:0] penetration;

	modport source (
		output valid, first_velocity, second_velocity, first_acceleration,
		second_acceleration, first_position, second_position, first_inverse_mass,
		second_inverse_mass, has_second, contact_normal, restitution, penetration,
		input ready
	);
	modport sink (
		input valid, first_velocity, second_velocity, first_acceleration,
		second_acceleration, first_position, second_position, first_inverse_mass,
		second_inverse_mass, has_second, contact_normal, restitution, penetration,
		output ready
	);
endinterface

[hw/rtl/pcr_result_if.sv]
// Result channel: one beat carries the resolved contact.
// Depends on pcr_pkg.
interface pcr_result_if;
	logic                      valid;
	logic                      ready;
	logic [pcr_pkg::VEC_W-1:0] new_first_velocity;
	logic [pcr_pkg::VEC_W-1:0] new_second_velocity;
	logic [pcr_pkg::VEC_W-1:0] new_first_position;
	logic [pcr_pkg::VEC_W-1:0] new_second_position;
	logic                      impulse_applied;
	logic                      position_corrected;

	modport source (
		output valid, new_first_velocity, new_second_velocity, new_first_position,
		new_second_position, impulse_applied, position_corrected,
		input ready
	);
	modport sink (
		input valid, new_first_velocity, new_second_velocity, new_first_position,
		new_second_position, impulse_applied, position_corrected,
		output ready
	);
endinterface

[hw/rtl/pcr_cfg_if.sv]
// Configuration write channel for the time step register.
// Depends on pcr_pkg.
interface pcr_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [pcr_pkg::TS_W-1:0] time_step;

	modport source (output valid, time_step, input ready);
	modport sink (input valid, time_step, output ready);
endinterface

[hw/rtl/pcr_div.sv]
// Pipelined restoring divider, NS register stages, several quotient bits per stage.
// Requires dividend >> QW to be below divisor. No package dependencies.
module pcr_div #(
	parameter int QW = 36,
	parameter int DW = 17,
	parameter int NS = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [QW+DW-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic [QW-1:0]    quotient,
	output logic             rem_nz
);

	localparam int BPS = (QW + NS - 1) / NS;

	logic [DW-1:0] rem_s  [NS];
	logic [QW-1:0] work_s [NS];
	logic [DW-1:0] dvs_s  [NS];

	for (genvar s = 0; s < NS; s++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] dvs_in;
		logic [QW-1:0] work_in;
		logic [DW-1:0] rem_nx;
		logic [QW-1:0] work_nx;
		logic [DW:0]   trial;

		if (s == 0) begin : g_first
			assign rem_in  = dividend[QW+DW-1:QW];
			assign work_in = dividend[QW-1:0];
			assign dvs_in  = divisor;
		end else begin : g_next
			assign rem_in  = rem_s[s-1];
			assign work_in = work_s[s-1];
			assign dvs_in  = dvs_s[s-1];
		end

		// dividend bits leave the top of work, quotient bits enter at the bottom
		always_comb begin
			rem_nx  = rem_in;
			work_nx = work_in;
			trial   = '0;
			for (int j = 0; j < BPS; j++) begin
				if (s * BPS + j < QW) begin
					trial   = {rem_nx, work_nx[QW-1]};
					work_nx = {work_nx[QW-2:0], 1'b0};
					if (trial >= {1'b0, dvs_in}) begin
						trial      = trial - {1'b0, dvs_in};
						work_nx[0] = 1'b1;
					end
					rem_nx = trial[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s]  <= rem_nx;
				work_s[s] <= work_nx;
				dvs_s[s]  <= dvs_in;
			end
		end
	end

	assign quotient = work_s[NS-1];
	assign rem_nz   = |rem_s[NS-1];

endmodule

[hw/rtl/particle_contact_resolver.sv]
// Particle contact resolver: takes one contact per clock while the output buffer
// has room and returns one resolved contact for each, in order. Eight stages form
// the separating velocity, the resting-contact target and the velocity change,
// DIV_STAGES stages split it by inverse mass in two pipelined restoring dividers,
// and three stages apply and saturate. Two result beats are buffered at the
// output, so contacts keep flowing while a finished result waits; a full buffer
// stalls the whole pipeline. Write time_step only while no contact is in flight.
// Depends on pcr_pkg, the channel interfaces and pcr_div.
module particle_contact_resolver #(
	parameter int DIV_STAGES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	pcr_contact_if.sink  contact,
	pcr_result_if.source result,
	pcr_cfg_if.sink      cfg
);

	localparam int LW     = pcr_pkg::LANE_W;
	localparam int DQW    = pcr_pkg::DQ_W;
	localparam int PROD_W = DQW + pcr_pkg::IM_W;
	localparam int PQW    = pcr_pkg::PEN_QW;
	localparam int LAT    = DIV_STAGES + 11;

	typedef struct packed {
		logic [pcr_pkg::VEC_W-1:0]  v0;
		logic [pcr_pkg::VEC_W-1:0]  v1;
		logic [pcr_pkg::VEC_W-1:0]  p0;
		logic [pcr_pkg::VEC_W-1:0]  p1;
		logic [pcr_pkg::VEC_W-1:0]  n;
		logic [pcr_pkg::IM_W-1:0]   im0;
		logic [pcr_pkg::TOT_W-1:0]  tot;
		logic [pcr_pkg::E_W-1:0]    e;
		logic signed [LW-1:0]       pen;
		logic                       imp;
		logic                       cor;
		logic [DQW-1:0]             dq;
	} carry_t;

	typedef struct packed {
		logic [pcr_pkg::VEC_W-1:0] v0n;
		logic [pcr_pkg::VEC_W-1:0] v1n;
		logic [pcr_pkg::VEC_W-1:0] p0n;
		logic [pcr_pkg::VEC_W-1:0] p1n;
		logic                      imp;
		logic                      cor;
	} res_t;

	function automatic logic signed [LW-1:0] lane(input logic [pcr_pkg::VEC_W-1:0] p,
			input int c);
		return p[LW*c +: LW];
	endfunction

	function automatic logic signed [55:0] rnd(input logic signed [55:0] x, input int s);
		return (x + (56'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [LW-1:0] sat16(input logic signed [55:0] x);
		if (x > 56'sd32767)
			return 16'h7fff;
		else if (x < -56'sd32768)
			return 16'h8000;
		else
			return x[LW-1:0];
	endfunction

	// configuration
	logic [pcr_pkg::TS_W-1:0] time_step_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			time_step_q <= pcr_pkg::TIME_STEP_RST;
		else if (cfg.valid)
			time_step_q <= cfg.time_step;
	end

	// global advance: hold everything while the output buffer is full
	logic [1:0] obuf_cnt_q;
	logic       adv;
	logic       accept;
	logic [LAT-1:0] vld_s;

	assign adv           = (obuf_cnt_q != 2'd2);
	assign contact.ready = adv;
	assign accept        = contact.valid & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[LAT-2:0], accept};
	end

	// stage 1: mask the absent particle, lane differences
	carry_t             c_c;
	logic signed [16:0] dv_c [3];
	logic signed [16:0] da_c [3];
	logic [pcr_pkg::VEC_W-1:0] a1_c;

	always_comb begin
		c_c     = '0;
		c_c.v0  = contact.first_velocity;
		c_c.v1  = contact.has_second ? contact.second_velocity : '0;
		c_c.p0  = contact.first_position;
		c_c.p1  = contact.has_second ? contact.second_position : '0;
		c_c.n   = contact.contact_normal;
		c_c.im0 = contact.first_inverse_mass;
		c_c.tot = {1'b0, contact.first_inverse_mass}
			+ {1'b0, (contact.has_second ? contact.second_inverse_mass : 16'd0)};
		c_c.e   = contact.restitution;
		c_c.pen = contact.penetration;
		a1_c    = contact.has_second ? contact.second_acceleration : '0;
		for (int c = 0; c < 3; c++) begin
			dv_c[c] = 17'(lane(c_c.v0, c)) - 17'(lane(c_c.v1, c));
			da_c[c] = 17'(lane(contact.first_acceleration, c)) - 17'(lane(a1_c, c));
		end
	end

	carry_t             c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8;
	carry_t             c4_c, c7_c;
	logic signed [16:0] dv_s1 [3];
	logic signed [16:0] da_s1 [3];
	logic signed [32:0] pv_s2 [3];
	logic signed [32:0] pa_s2 [3];
	logic signed [34:0] sep_s3, acc_s3;
	logic signed [50:0] a_s4;
	logic signed [35:0] nsep_s4, nsep_s5, nsep_s6;
	logic signed [45:0] nse_s4, nse_s5;
	logic signed [59:0] ae_s5;
	logic               a_neg_s5;
	logic signed [53:0] tgt_c;
	logic [52:0]        tgt_s6;
	logic [53:0]        d_c;
	logic [PROD_W-1:0]  prod_s8;
	logic [2*LW-2:0]    pp_s8;

	always_comb begin
		tgt_c = (54'(nse_s5) <<< 8) + (a_neg_s5 ? 54'(ae_s5 >>> 8) : 54'sd0);
		d_c   = 54'(tgt_s6) + (54'(nsep_s6) << 16);
		c4_c     = c_s3;
		c4_c.imp = (sep_s3 <= 35'sd0) && (c_s3.tot != '0);
		c4_c.cor = (c_s3.pen > 16'sd0) && (c_s3.tot != '0);
		c7_c     = c_s6;
		c7_c.dq  = d_c[16 +: DQW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c_c;
			for (int c = 0; c < 3; c++) begin
				dv_s1[c] <= dv_c[c];
				da_s1[c] <= da_c[c];
			end

			c_s2 <= c_s1;
			for (int c = 0; c < 3; c++) begin
				pv_s2[c] <= 33'(dv_s1[c]) * 33'(lane(c_s1.n, c));
				pa_s2[c] <= 33'(da_s1[c]) * 33'(lane(c_s1.n, c));
			end

			c_s3   <= c_s2;
			sep_s3 <= 35'(pv_s2[0]) + 35'(pv_s2[1]) + 35'(pv_s2[2]);
			acc_s3 <= 35'(pa_s2[0]) + 35'(pa_s2[1]) + 35'(pa_s2[2]);

			c_s4     <= c4_c;
			a_s4     <= 51'(acc_s3) * 51'($signed({1'b0, time_step_q}));
			nsep_s4  <= -36'(sep_s3);
			nse_s4   <= 46'(-36'(sep_s3)) * 46'($signed({1'b0, c_s3.e}));

			c_s5     <= c_s4;
			ae_s5    <= 60'(a_s4) * 60'($signed({1'b0, c_s4.e}));
			a_neg_s5 <= a_s4[50];
			nse_s5   <= nse_s4;
			nsep_s5  <= nsep_s4;

			// clamp the resting-contact target at zero
			c_s6    <= c_s5;
			tgt_s6  <= tgt_c[53] ? '0 : tgt_c[52:0];
			nsep_s6 <= nsep_s5;

			c_s7    <= c7_c;

			c_s8    <= c_s7;
			prod_s8 <= PROD_W'(c_s7.dq) * PROD_W'(c_s7.im0);
			pp_s8   <= (2*LW-1)'(c_s7.pen[PQW-1:0]) * (2*LW-1)'(c_s7.im0);
		end
	end

	// split by inverse mass
	logic [DQW-1:0] q_w;
	logic           q_w_nz;
	logic [PQW-1:0] q_m;
	logic           q_m_nz;

	pcr_div #(.QW(DQW), .DW(pcr_pkg::TOT_W), .NS(DIV_STAGES)) u_div_w (
		.clk      (clk),
		.en       (adv),
		.dividend ({1'b0, prod_s8}),
		.divisor  (c_s8.tot),
		.quotient (q_w),
		.rem_nz   (q_w_nz)
	);

	pcr_div #(.QW(PQW), .DW(pcr_pkg::TOT_W), .NS(DIV_STAGES)) u_div_m (
		.clk      (clk),
		.en       (adv),
		.dividend ({1'b0, pp_s8}),
		.divisor  (c_s8.tot),
		.quotient (q_m),
		.rem_nz   (q_m_nz)
	);

	carry_t c_d [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_d[0] <= c_s8;
			for (int k = 1; k < DIV_STAGES; k++)
				c_d[k] <= c_d[k-1];
		end
	end

	// stage 9..11: second share is the rest, then apply along the normal
	carry_t             c_s9, c_s10;
	logic [DQW-1:0]     w0_s9, w1_s9;
	logic [PQW-1:0]     m0_s9, m1_s9;
	logic signed [DQW+16:0] wv0_s10 [3];
	logic signed [DQW+16:0] wv1_s10 [3];
	logic signed [31:0] mp0_s10 [3];
	logic signed [31:0] mp1_s10 [3];
	res_t               res_c, res_s11;
	carry_t             c_last;

	assign c_last = c_d[DIV_STAGES-1];

	always_comb begin
		res_c     = '0;
		res_c.imp = c_s10.imp;
		res_c.cor = c_s10.cor;
		for (int c = 0; c < 3; c++) begin
			res_c.v0n[LW*c +: LW] = sat16(56'(lane(c_s10.v0, c))
				+ rnd(56'(wv0_s10[c]), 16));
			res_c.v1n[LW*c +: LW] = sat16(56'(lane(c_s10.v1, c))
				- rnd(56'(wv1_s10[c]), 16));
			res_c.p0n[LW*c +: LW] = sat16(56'(lane(c_s10.p0, c))
				+ rnd(56'(mp0_s10[c]), 8));
			res_c.p1n[LW*c +: LW] = sat16(56'(lane(c_s10.p1, c))
				- rnd(56'(mp1_s10[c]), 8));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s9  <= c_last;
			w0_s9 <= c_last.imp ? q_w : '0;
			w1_s9 <= c_last.imp ? (c_last.dq - q_w - DQW'(q_w_nz)) : '0;
			m0_s9 <= c_last.cor ? q_m : '0;
			m1_s9 <= c_last.cor ? (c_last.pen[PQW-1:0] - q_m - PQW'(q_m_nz)) : '0;

			c_s10 <= c_s9;
			for (int c = 0; c < 3; c++) begin
				wv0_s10[c] <= (DQW+17)'($signed({1'b0, w0_s9})) * (DQW+17)'(lane(c_s9.n, c));
				wv1_s10[c] <= (DQW+17)'($signed({1'b0, w1_s9})) * (DQW+17)'(lane(c_s9.n, c));
				mp0_s10[c] <= 32'($signed({1'b0, m0_s9})) * 32'(lane(c_s9.n, c));
				mp1_s10[c] <= 32'($signed({1'b0, m1_s9})) * 32'(lane(c_s9.n, c));
			end

			res_s11 <= res_c;
		end
	end

	// output buffer, two beats deep
	res_t obuf_q [2];
	logic wr_q, rd_q;
	logic push, pop;

	assign push = adv & vld_s[LAT-1];
	assign pop  = result.valid & result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_cnt_q <= '0;
			wr_q       <= 1'b0;
			rd_q       <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			obuf_cnt_q <= obuf_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			obuf_q[wr_q] <= res_s11;
	end

	assign result.valid               = (obuf_cnt_q != 2'd0);
	assign result.new_first_velocity  = obuf_q[rd_q].v0n;
	assign result.new_second_velocity = obuf_q[rd_q].v1n;
	assign result.new_first_position  = obuf_q[rd_q].p0n;
	assign result.new_second_position = obuf_q[rd_q].p1n;
	assign result.impulse_applied     = obuf_q[rd_q].imp;
	assign result.position_corrected  = obuf_q[rd_q].cor;

endmodule

[bench/particle_contact_resolver_tb.sv]
// Self-checking bench for the particle contact resolver: drives contacts and time step
// writes, predicts each resolved contact in fixed point and compares every result beat.
// Depends on pcr_pkg, the three channel interfaces and particle_contact_resolver.
module particle_contact_resolver_tb;

	localparam int LANE_W = pcr_pkg::LANE_W;
	localparam int VEC_W  = pcr_pkg::VEC_W;
	localparam int IM_W   = pcr_pkg::IM_W;
	localparam int E_W    = pcr_pkg::E_W;
	localparam int TS_W   = pcr_pkg::TS_W;
	localparam logic [TS_W-1:0] TIME_STEP_RST = pcr_pkg::TIME_STEP_RST;

	localparam int LATENCY    = 8 + 11 + 4;
	localparam int CYCLE_CAP  = 400000;
	localparam int N_RANDOM   = 1200;

	typedef struct packed {
		logic [VEC_W-1:0]  v0, v1, a0, a1, p0, p1;
		logic [IM_W-1:0]   im0, im1;
		logic              two;
		logic [VEC_W-1:0]  n;
		logic [E_W-1:0]    e;
		logic [LANE_W-1:0] pen;
	} contact_t;

	typedef struct packed {
		logic [VEC_W-1:0] v0, v1, p0, p1;
		logic             imp, cor;
	} resolved_t;

	localparam int SHOW_W = $bits(resolved_t);

	typedef struct {
		contact_t  c;
		bit        known;
		resolved_t r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;

	pcr_contact_if contact();
	pcr_result_if  result();
	pcr_cfg_if     cfg();

	particle_contact_resolver i_dut (
		.clk(clk), .arst_n(arst_n), .contact(contact), .result(result), .cfg(cfg)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic [TS_W-1:0] step_model = TIME_STEP_RST;
	resolved_t       pending[$];
	int              mismatches = 0;
	int              results_seen = 0;
	int              cycles = 0;
	bit              rx_calm = 0;
	int              impulses = 0, corrections = 0;

	function automatic longint lane_of(logic [VEC_W-1:0] v, int c);
		return longint'($signed(v[c*LANE_W +: LANE_W]));
	endfunction

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic logic [LANE_W-1:0] clamp16(longint t);
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[LANE_W-1:0];
	endfunction

	function automatic resolved_t resolve_contact(contact_t c, logic [TS_W-1:0] ts);
		resolved_t r;
		longint im0, im1, e, pen, total, sep, acc, target, a, d, dq, w0, w1, m0, m1;
		longint v0[3], v1[3], p0[3], p1[3], n[3];
		im0 = c.im0;
		im1 = c.two ? longint'(c.im1) : 0;
		e = c.e;
		pen = longint'($signed(c.pen));
		total = im0 + im1;
		sep = 0;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			n[i] = lane_of(c.n, i);
			v0[i] = lane_of(c.v0, i);
			p0[i] = lane_of(c.p0, i);
			v1[i] = c.two ? lane_of(c.v1, i) : 0;
			p1[i] = c.two ? lane_of(c.p1, i) : 0;
			sep += (v0[i] - v1[i]) * n[i];
			acc += (lane_of(c.a0, i) - (c.two ? lane_of(c.a1, i) : 0)) * n[i];
		end
		r.imp = 0;
		r.cor = 0;
		if (sep <= 0 && total > 0) begin
			target = (-sep) * e * 256;
			a = acc * longint'(ts);
			if (a < 0) begin
				target += floor_sh(a * e, 8);
				if (target < 0) target = 0;
			end
			d = target - sep * 65536;
			dq = floor_sh(d, 16);
			w0 = dq * im0 / total;
			w1 = dq * im1 / total;
			for (int i = 0; i < 3; i++) begin
				v0[i] += floor_sh(w0 * n[i] + 32768, 16);
				v1[i] -= floor_sh(w1 * n[i] + 32768, 16);
			end
			r.imp = 1;
		end
		if (pen > 0 && total > 0) begin
			m0 = pen * im0 / total;
			m1 = pen * im1 / total;
			for (int i = 0; i < 3; i++) begin
				p0[i] += floor_sh(m0 * n[i] + 128, 8);
				p1[i] -= floor_sh(m1 * n[i] + 128, 8);
			end
			r.cor = 1;
		end
		for (int i = 0; i < 3; i++) begin
			r.v0[i*LANE_W +: LANE_W] = clamp16(v0[i]);
			r.v1[i*LANE_W +: LANE_W] = c.two ? clamp16(v1[i]) : '0;
			r.p0[i*LANE_W +: LANE_W] = clamp16(p0[i]);
			r.p1[i*LANE_W +: LANE_W] = c.two ? clamp16(p1[i]) : '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [SHOW_W-1:0] want,
			logic [SHOW_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d, %s: expected %h, got %h", results_seen, what, want, got);
	endtask

	// result side: random stalls, check every beat against the oldest prediction
	initial begin
		int stall;
		result.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (pending.size() == 0) begin
					report_mismatch("unexpected beat", '0, SHOW_W'(result.new_first_velocity));
				end else begin
					resolved_t w;
					w = pending.pop_front();
					if (result.new_first_velocity !== w.v0)
						report_mismatch("new_first_velocity", SHOW_W'(w.v0),
							SHOW_W'(result.new_first_velocity));
					if (result.new_second_velocity !== w.v1)
						report_mismatch("new_second_velocity", SHOW_W'(w.v1),
							SHOW_W'(result.new_second_velocity));
					if (result.new_first_position !== w.p0)
						report_mismatch("new_first_position", SHOW_W'(w.p0),
							SHOW_W'(result.new_first_position));
					if (result.new_second_position !== w.p1)
						report_mismatch("new_second_position", SHOW_W'(w.p1),
							SHOW_W'(result.new_second_position));
					if (result.impulse_applied !== w.imp)
						report_mismatch("impulse_applied", SHOW_W'(w.imp),
							SHOW_W'(result.impulse_applied));
					if (result.position_corrected !== w.cor)
						report_mismatch("position_corrected", SHOW_W'(w.cor),
							SHOW_W'(result.position_corrected));
				end
				results_seen++;
			end
			if (!rx_calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 15);
				result.ready <= 0;
				repeat (stall) @(posedge clk);
				result.ready <= 1;
			end else begin
				result.ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_contact(contact_t c, bit known, resolved_t r);
		resolved_t p;
		contact.valid <= 1;
		{contact.first_velocity, contact.second_velocity, contact.first_acceleration,
		 contact.second_acceleration, contact.first_position, contact.second_position,
		 contact.first_inverse_mass, contact.second_inverse_mass, contact.has_second,
		 contact.contact_normal, contact.restitution, contact.penetration} <= c;
		do @(posedge clk); while (!contact.ready);
		p = resolve_contact(c, step_model);
		if (known && p !== r)
			report_mismatch("table row disagrees with prediction", r, p);
		pending.push_back(known ? r : p);
		impulses += p.imp;
		corrections += p.cor;
	endtask

	task automatic drain_pipe();
		contact.valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_step(logic [TS_W-1:0] ts);
		drain_pipe();
		cfg.valid <= 1;
		cfg.time_step <= ts;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		step_model = ts;
	endtask

	function automatic logic [VEC_W-1:0] rand_vec(int mag);
		logic [VEC_W-1:0] v;
		for (int i = 0; i < 3; i++)
			v[i*LANE_W +: LANE_W] = $urandom_range(0, 7) == 0 ? LANE_W'($urandom()) :
				LANE_W'($signed($urandom_range(0, 2*mag)) - mag);
		return v;
	endfunction

	function automatic contact_t rand_contact();
		contact_t c;
		c.v0 = rand_vec(2048);
		c.v1 = rand_vec(2048);
		c.a0 = rand_vec(4096);
		c.a1 = rand_vec(4096);
		c.p0 = rand_vec(8192);
		c.p1 = rand_vec(8192);
		c.n = rand_vec(256);
		c.im0 = $urandom_range(0, 5) == 0 ? 16'(0) : 16'($urandom());
		c.im1 = $urandom_range(0, 5) == 0 ? 16'(0) : 16'($urandom());
		c.two = 1'($urandom_range(0, 1));
		c.e = $urandom_range(0, 8) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 256));
		c.pen = LANE_W'($urandom());
		return c;
	endfunction

	initial begin
		row_t      plan[$];
		row_t      row;
		contact_t  c;
		resolved_t z;
		int        gap;
		logic [TS_W-1:0] steps[4];
		contact.valid <= 0;
		contact.first_velocity <= '0;
		contact.second_velocity <= '0;
		contact.first_acceleration <= '0;
		contact.second_acceleration <= '0;
		contact.first_position <= '0;
		contact.second_position <= '0;
		contact.first_inverse_mass <= '0;
		contact.second_inverse_mass <= '0;
		contact.has_second <= 0;
		contact.contact_normal <= '0;
		contact.restitution <= '0;
		contact.penetration <= '0;
		cfg.valid <= 0;
		cfg.time_step <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows: all-zero contact, separating, head-on, scenery, extremes
		c = '0;
		z = '0;
		row.c = c; row.known = 1; row.r = z; plan.push_back(row);
		c.im0 = 16'h0100; c.n = {16'd0, 16'd0, 16'h0100};
		z.imp = 1;
		row.c = c; row.r = z; plan.push_back(row);
		c.v0 = {16'd0, 16'd0, 16'h0100};
		z.v0 = c.v0; z.imp = 0;
		row.c = c; row.r = z; plan.push_back(row);
		row.known = 0;
		c.v0 = {16'd0, 16'd0, 16'hff00}; c.e = 9'd256; row.c = c; plan.push_back(row);
		c.e = 9'd511; row.c = c; plan.push_back(row);
		c.two = 1; c.im1 = 16'h0100; c.v1 = {3{16'h7fff}}; c.p1 = {3{16'h8000}};
		c.pen = 16'h0080; row.c = c; plan.push_back(row);
		c.pen = 16'h7fff; row.c = c; plan.push_back(row);
		c.pen = 16'h8000; row.c = c; plan.push_back(row);
		c.two = 0; c.pen = 16'h0100; row.c = c; plan.push_back(row);
		c.im0 = 0; c.im1 = 16'hffff; row.c = c; plan.push_back(row);
		c.two = 1; c.im0 = 16'hffff; c.a0 = {3{16'h8000}}; c.a1 = {3{16'h7fff}};
		c.n = {3{16'h7fff}}; row.c = c; plan.push_back(row);
		c.n = {3{16'h8000}}; c.v0 = {3{16'h8000}}; row.c = c; plan.push_back(row);
		c.v0 = '0; c.v1 = '0; c.a0 = {16'd0, 16'd0, 16'hf000}; c.a1 = '0;
		c.n = {16'd0, 16'd0, 16'h0100}; c.e = 9'd128; row.c = c; plan.push_back(row);
		c = rand_contact(); c.two = 0; c.im0 = 0;
		z = '0; z.v0 = c.v0; z.p0 = c.p0;
		row.c = c; row.known = 1; row.r = z; plan.push_back(row);
		row.known = 0;
		for (int i = 0; i < 6; i++) begin
			row.c = rand_contact(); plan.push_back(row);
		end

		foreach (plan[i]) send_contact(plan[i].c, plan[i].known, plan[i].r);

		steps = '{16'hffff, 16'h0000, 16'h8000, TIME_STEP_RST};
		for (int ph = 0; ph < 4; ph++) begin
			write_step(steps[ph]);
			for (int k = 0; k < N_RANDOM / 4; k++) begin
				if (ph == 3 && k > N_RANDOM / 8) rx_calm = 1;
				if (!rx_calm && $urandom_range(0, 9) == 0) begin
					gap = $urandom_range(1, 15);
					contact.valid <= 0;
					repeat (gap) @(posedge clk);
				end
				send_contact(rand_contact(), 0, z);
			end
		end

		drain_pipe();
		$display("ran %0d contacts over four time step settings: %0d impulses, %0d corrections",
			results_seen, impulses, corrections);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_contact_if.sv
hw/rtl/pcr_result_if.sv
hw/rtl/pcr_cfg_if.sv
hw/rtl/pcr_div.sv
hw/rtl/particle_contact_resolver.sv
bench/particle_contact_resolver_tb.sv
